// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the hash table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tslht_pkg.sv -----
// Package for the two-slot hash table: widths, register indexes, command codes.
`timescale 1ns / 1ps

package tslht_pkg;

	// Default table size (log2 of the slot count)
	localparam int SLOTS_LOG2_DEF = 12;

	// Field widths
	localparam int KEY_W      = 64;
	localparam int COUNT_W    = 64;
	localparam int SLOT_W     = KEY_W + COUNT_W;
	localparam int IN_TDATA_W = KEY_W + KEY_W + COUNT_W;

	// Configuration channel
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SLOTS    = 2'd1;
	localparam logic [3:0] LOG2_SLOTS_RESET = 4'd12;

	// Request commands
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_PROBE = 1'b1;

endpackage

// ----- sv/two_slot_lockless_hash_table_top.sv -----
// Top level of the two-slot bucket hash table with depth-preferred replacement.
`timescale 1ns / 1ps

// Usage:
// Requests enter on the s_axis group: s_axis_tuser is the command (0 store,
// 1 probe), s_axis_tdata carries key_hi, key_lo and count_value. Each request
// gives one result on the m_axis group: m_axis_tuser is hit, m_axis_tdata is
// count_found (both zero on a store, a miss, or a disabled table). Registers are
// written over cfg_valid/cfg_index/cfg_data by the user while the block is idle,
// not enforced by the block; index 0 is table_enabled, index 1 is log2_slots_in_use.
// Timing: the block takes one request at a time and drops s_axis_tready from
// acceptance until the result is loaded into the output register. After
// acceptance, a store or a first-slot probe steps through S_READ0, S_CHECK0
// and S_DONE, a probe that reaches the second slot adds S_CHECK1, and a
// disabled table goes straight to S_DONE; a new request is taken in the
// following cycle. The sequence is set by the single RAM port, which reads
// slot by slot, and the one shared compare unit.
// Reset: a clearing pass writes zeros to all 2^SLOTS_LOG2 slots, one per cycle,
// with s_axis_tready low; cfg writes are taken meanwhile. A stalled result waits
// in the output register; a finished request waits for it to drain before the
// block takes the next one.

module two_slot_lockless_hash_table_top #(
	parameter int SLOTS_LOG2 = tslht_pkg::SLOTS_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [63:0] key_hi, [127:64] key_lo, [191:128] count_value
	input  logic [tslht_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  logic                              s_axis_tuser,
	// Result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [63:0] count_found
	output logic [tslht_pkg::COUNT_W-1:0]     m_axis_tdata,
	// [0] hit
	output logic                              m_axis_tuser,
	// Configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tslht_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tslht_pkg::CFG_DATA_W-1:0]  cfg_data
);

	`include "assert_macros.svh"

	import tslht_pkg::*;

	localparam int ADDR_W = SLOTS_LOG2;
	localparam int DEPTH  = 1 << SLOTS_LOG2;
	localparam logic [4:0] SLOTS_LOG2_5 = 5'(SLOTS_LOG2);
	localparam logic [ADDR_W-1:0] ODD_SLOT = ADDR_W'(1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ0,
		S_CHECK0,
		S_CHECK1,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                enabled_q;
	logic [3:0]          log2_q;
	logic                cmd_q;
	logic [KEY_W-1:0]    key_hi_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ADDR_W-1:0]   base_q;
	logic                res_hit_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic                out_valid_q;
	logic                out_hit_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic [3:0]          lg_lo;
	logic [4:0]          lg_eff;
	logic [ADDR_W-1:0]   mask;
	logic [KEY_W-1:0]    in_key_lo;
	logic [ADDR_W-1:0]   in_base;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [SLOT_W-1:0]   ram_wdata;
	logic [SLOT_W-1:0]   ram_rdata;
	logic [KEY_W-1:0]    rd_check;
	logic [COUNT_W-1:0]  rd_count;

	logic [COUNT_W-1:0]  unit_a;
	logic [COUNT_W-1:0]  unit_b;
	logic                unit_eq;
	logic                unit_lt;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			log2_q    <= LOG2_SLOTS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TABLE_ENABLED: enabled_q <= cfg_data[0];
				CFG_LOG2_SLOTS:    log2_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Bucket index: clamp the size, mask the low key word to an even slot
	always_comb begin
		lg_lo  = (log2_q == 4'd0) ? 4'd1 : log2_q;
		lg_eff = ({1'b0, lg_lo} > SLOTS_LOG2_5) ? SLOTS_LOG2_5 : {1'b0, lg_lo};
		for (int i = 0; i < ADDR_W; i++) begin
			mask[i] = (i != 0) && (5'(i) < lg_eff);
		end
	end

	assign in_key_lo = s_axis_tdata[2*KEY_W-1:KEY_W];
	assign in_base   = in_key_lo[ADDR_W-1:0] & mask;

	// Slot word: [63:0] check, [127:64] count
	assign rd_check = ram_rdata[KEY_W-1:0];
	assign rd_count = ram_rdata[SLOT_W-1:KEY_W];

	// Shared compare unit: count order on store, key match on probe
	always_comb begin
		if (cmd_q == CMD_STORE) begin
			unit_a = count_q;
			unit_b = rd_count;
		end else begin
			unit_a = key_hi_q;
			unit_b = rd_check ^ rd_count;
		end
		unit_eq = (unit_a == unit_b);
		unit_lt = (unit_a < unit_b);
	end

	// RAM port: clearing pass, slot reads, store write
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = base_q;
		ram_wdata = {count_q, key_hi_q ^ count_q};
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			S_CHECK0: begin
				if (cmd_q == CMD_STORE) begin
					ram_we   = 1'b1;
					ram_addr = unit_lt ? (base_q | ODD_SLOT) : base_q;
				end else begin
					ram_addr = base_q | ODD_SLOT;
				end
			end
			default: ;
		endcase
	end

	tslht_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cmd_q       <= CMD_STORE;
			key_hi_q    <= '0;
			count_q     <= '0;
			base_q      <= '0;
			res_hit_q   <= 1'b0;
			res_count_q <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_count_q <= '0;
		end else begin
			// Output valid: load a finished result, or drop once taken
			if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q    <= s_axis_tuser;
						key_hi_q <= s_axis_tdata[KEY_W-1:0];
						count_q  <= s_axis_tdata[IN_TDATA_W-1:2*KEY_W];
						base_q   <= in_base;
						if (enabled_q) begin
							state_q <= S_READ0;
						end else begin
							res_hit_q   <= 1'b0;
							res_count_q <= '0;
							state_q     <= S_DONE;
						end
					end
				end
				S_READ0: begin
					state_q <= S_CHECK0;
				end
				S_CHECK0: begin
					if (cmd_q == CMD_STORE) begin
						res_hit_q   <= 1'b0;
						res_count_q <= '0;
						state_q     <= S_DONE;
					end else if (unit_eq) begin
						res_hit_q   <= 1'b1;
						res_count_q <= rd_count;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_CHECK1;
					end
				end
				S_CHECK1: begin
					res_hit_q   <= unit_eq;
					res_count_q <= unit_eq ? rd_count : '0;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_hit_q   <= res_hit_q;
						out_count_q <= res_count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = out_count_q;

	// Checks
	`ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"request taken while the previous one is in progress")
	`ASSERT_IMPLIES(a_store_in_bucket, ram_we && (state_q == S_CHECK0),
		(ram_addr & ~ODD_SLOT) == base_q, "store write outside its bucket")
	`ASSERT_IMPLIES(a_store_result_zero, (state_q == S_DONE) && (cmd_q == CMD_STORE),
		!res_hit_q && (res_count_q == '0), "store request produced a nonzero result")

endmodule

// ----- sv/tslht_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tslht_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access per cycle, read data in the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
